// ===== design/dtsg_pkg.sv =====
package dtsg_pkg;

   // Default sizing of the oscillators and the sine table
   localparam int unsigned DEF_PHASE_BITS      = 32;
   localparam int unsigned DEF_TABLE_ADDR_BITS = 10;
   localparam int unsigned DEF_SINE_BITS       = 16;

   // Fixed field widths
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned STEP_W      = 32;
   localparam int unsigned VOLUME_W    = 14;
   localparam int unsigned SCALED_W    = VOLUME_W + 1;
   localparam int unsigned SAMPLE_W    = 16;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TONE1_STEP = 2'd0,
      CSR_TONE2_STEP = 2'd1,
      CSR_VOLUME     = 2'd2
   } csr_index_type;

   // Reset values: about 350 Hz and 440 Hz at 48 kHz, moderate volume
   localparam logic [STEP_W-1:0]   TONE1_STEP_RESET = 32'd31350126;
   localparam logic [STEP_W-1:0]   TONE2_STEP_RESET = 32'd39403369;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET     = 14'd3000;

   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // One entry of the quarter-wave table: Horner evaluation of the sine
   // series in Q30, scaled to the full positive code and rounded.
   // Only evaluated at elaboration.
   function automatic longint unsigned sine_entry(input int unsigned idx,
                                                  input int unsigned addr_bits,
                                                  input int unsigned sine_bits);
      longint unsigned one;
      longint unsigned amp;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned h;
      longint unsigned s;
      longint unsigned v;
      one = 64'd1 << 30;
      amp = (64'd1 << (sine_bits - 1)) - 64'd1;
      x   = (64'(idx) * HALF_PI_Q30) >> addr_bits;
      x2  = (x * x) >> 30;
      h   = one;
      h   = one - ((x2 * h) >> 30) / 64'd156;
      h   = one - ((x2 * h) >> 30) / 64'd110;
      h   = one - ((x2 * h) >> 30) / 64'd72;
      h   = one - ((x2 * h) >> 30) / 64'd42;
      h   = one - ((x2 * h) >> 30) / 64'd20;
      h   = one - ((x2 * h) >> 30) / 64'd6;
      s   = (x * h) >> 30;
      v   = (s * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

// ===== design/dtsg_sine_rom.sv =====
module dtsg_sine_rom #(
   parameter int unsigned TABLE_ADDR_BITS = dtsg_pkg::DEF_TABLE_ADDR_BITS,
   parameter int unsigned SINE_BITS       = dtsg_pkg::DEF_SINE_BITS
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [TABLE_ADDR_BITS:0]   rd_addr_a,
   input  logic [TABLE_ADDR_BITS:0]   rd_addr_b,
   output logic [SINE_BITS-2:0]       rd_data_a,
   output logic [SINE_BITS-2:0]       rd_data_b
);
   import dtsg_pkg::*;

   localparam int unsigned DEPTH = (1 << TABLE_ADDR_BITS) + 1;

   logic [SINE_BITS-2:0] table_w [DEPTH];
   logic [SINE_BITS-2:0] rd_data_a_ff;
   logic [SINE_BITS-2:0] rd_data_b_ff;

   // Quarter wave, both ends included
   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      assign table_w[g] = (SINE_BITS-1)'(sine_entry(g, TABLE_ADDR_BITS, SINE_BITS));
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= table_w[rd_addr_a];
         rd_data_b_ff <= table_w[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/dual_tone_sine_generator_top.sv =====
// Dual-tone sine generator. Every request transaction yields one stereo sample
// transaction: the sum of two sines, each looked up in a quarter-wave table at
// the top bits of its own phase accumulator, scaled by the volume register and
// truncated toward zero to signed 16 bits; left and right carry the same value
// and rsp_last echoes req_end_of_buffer. Both accumulators advance by their
// step registers when a request is taken, so the first sample after reset is at
// phase zero. A step is 2^32 divided by the period in samples. The block takes
// one request per cycle while the response side does not stall; each sample
// passes through registered table read, sum, volume multiply and sign restore
// stages in that order, and the table is a constant ROM of 2^TABLE_ADDR_BITS+1
// entries with two read ports. Write the CSRs only while no transaction is in
// flight. Volume up to 16383 never overflows the 16-bit sample.
module dual_tone_sine_generator_top #(
   parameter int unsigned PHASE_BITS      = dtsg_pkg::DEF_PHASE_BITS,
   parameter int unsigned TABLE_ADDR_BITS = dtsg_pkg::DEF_TABLE_ADDR_BITS,
   parameter int unsigned SINE_BITS       = dtsg_pkg::DEF_SINE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [dtsg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dtsg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_end_of_buffer,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dtsg_pkg::SAMPLE_W-1:0] rsp_left_sample,
   output logic signed [dtsg_pkg::SAMPLE_W-1:0] rsp_right_sample,
   output logic                               rsp_last
);
   import dtsg_pkg::*;

   localparam int unsigned PROD_W = SINE_BITS + VOLUME_W;
   localparam logic [TABLE_ADDR_BITS:0] QSIZE = (TABLE_ADDR_BITS+1)'(1 << TABLE_ADDR_BITS);

   // Configuration registers
   logic [STEP_W-1:0]   tone1_step_ff;
   logic [STEP_W-1:0]   tone2_step_ff;
   logic [VOLUME_W-1:0] volume_ff;

   // Oscillators
   logic [PHASE_BITS-1:0] phase_one_ff;
   logic [PHASE_BITS-1:0] phase_two_ff;
   logic [PHASE_BITS-1:0] phase_one_in;
   logic [PHASE_BITS-1:0] phase_two_in;

   // Stage enables: a stage moves when it is empty or the next one moves
   logic en1;
   logic en2;
   logic en3;
   logic en4;
   logic accept;

   // Stage 1: table read
   logic                     v1_ff;
   logic                     neg_a_ff;
   logic                     neg_b_ff;
   logic                     last1_ff;
   logic [TABLE_ADDR_BITS:0] addr_a_in;
   logic [TABLE_ADDR_BITS:0] addr_b_in;
   logic [SINE_BITS-2:0]     rom_a;
   logic [SINE_BITS-2:0]     rom_b;

   // Stage 2: signed sum, split into sign and magnitude
   logic                      v2_ff;
   logic                      last2_ff;
   logic                      neg2_ff;
   logic [SINE_BITS-1:0]      mag2_ff;
   logic signed [SINE_BITS:0] tone_a_in;
   logic signed [SINE_BITS:0] tone_b_in;
   logic signed [SINE_BITS:0] sum_in;
   logic [SINE_BITS-1:0]      mag2_in;

   // Stage 3: volume product
   logic              v3_ff;
   logic              last3_ff;
   logic              neg3_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // Stage 4: output register
   logic                       rsp_valid_ff;
   logic                       rsp_last_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [SCALED_W-1:0]        scaled_in;
   logic signed [SAMPLE_W-1:0] sample_in;

   assign en4    = !rsp_valid_ff || rsp_ready;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_valid && en1;

   assign req_ready = en1;

   // CSR writes; an unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         tone1_step_ff <= TONE1_STEP_RESET;
         tone2_step_ff <= TONE2_STEP_RESET;
         volume_ff     <= VOLUME_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TONE1_STEP: tone1_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_TONE2_STEP: tone2_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_VOLUME:     volume_ff     <= csr_wdata[VOLUME_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance both accumulators once per accepted transaction, wrapping a turn
   assign phase_one_in = phase_one_ff + PHASE_BITS'(tone1_step_ff);
   assign phase_two_in = phase_two_ff + PHASE_BITS'(tone2_step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_one_ff <= '0;
         phase_two_ff <= '0;
      end else if (accept) begin
         phase_one_ff <= phase_one_in;
         phase_two_ff <= phase_two_in;
      end
   end

   // Odd quadrants read the table backwards from the top entry
   function automatic logic [TABLE_ADDR_BITS:0] quarter_addr(input logic [PHASE_BITS-1:0] ph);
      logic [TABLE_ADDR_BITS:0] f;
      f = {1'b0, ph[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
      return ph[PHASE_BITS-2] ? QSIZE - f : f;
   endfunction

   assign addr_a_in = quarter_addr(phase_one_ff);
   assign addr_b_in = quarter_addr(phase_two_ff);

   dtsg_sine_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .SINE_BITS       (SINE_BITS)
   ) u_sine_rom (
      .clock     (clock),
      .rd_en     (en1),
      .rd_addr_a (addr_a_in),
      .rd_addr_b (addr_b_in),
      .rd_data_a (rom_a),
      .rd_data_b (rom_b)
   );

   // Stage 1: carry the lower-half sign bits alongside the table read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         neg_a_ff <= phase_one_ff[PHASE_BITS-1];
         neg_b_ff <= phase_two_ff[PHASE_BITS-1];
         last1_ff <= req_end_of_buffer;
      end
   end

   // Stage 2: apply signs, sum, take magnitude
   assign tone_a_in = neg_a_ff ? -$signed({2'b00, rom_a}) : $signed({2'b00, rom_a});
   assign tone_b_in = neg_b_ff ? -$signed({2'b00, rom_b}) : $signed({2'b00, rom_b});
   assign sum_in    = tone_a_in + tone_b_in;
   assign mag2_in   = sum_in[SINE_BITS] ? SINE_BITS'(-sum_in) : SINE_BITS'(sum_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         neg2_ff  <= sum_in[SINE_BITS];
         mag2_ff  <= mag2_in;
         last2_ff <= last1_ff;
      end
   end

   // Stage 3: scale magnitude by volume
   assign prod_in = PROD_W'(mag2_ff) * PROD_W'(volume_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         neg3_ff  <= neg2_ff;
         prod_ff  <= prod_in;
         last3_ff <= last2_ff;
      end
   end

   // Stage 4: drop the fraction bits of the magnitude, then restore the sign,
   // which truncates toward zero
   assign scaled_in = prod_ff[PROD_W-1 -: SCALED_W];
   assign sample_in = neg3_ff ? -$signed({1'b0, scaled_in}) : $signed({1'b0, scaled_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en4) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         sample_ff   <= sample_in;
         rsp_last_ff <= last3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = sample_ff;
   assign rsp_right_sample = sample_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
